// File: hdl/g711_companding_codec_unit_defines.svh
// assertion macros for the g711 companding codec checker
`ifndef G711_COMPANDING_CODEC_UNIT_DEFINES_SVH
`define G711_COMPANDING_CODEC_UNIT_DEFINES_SVH

// property checked only while out of reset
`define G711_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that also covers the reset cycles
`define G711_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/g711_pkg.sv
// shared types and constants of the g711 companding codec
package g711_pkg;

    typedef enum logic {
        LAW_ALAW  = 1'b0,
        LAW_MULAW = 1'b1
    } law_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } opcode_t;

    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 8;
    localparam int DEC_W    = 14;
    localparam int MAG_W    = 13;

    localparam logic [MAG_W-1:0]  ALAW_LIMIT  = 13'h0FFF;
    localparam logic [MAG_W-1:0]  MULAW_LIMIT = 13'h1FFF;
    localparam logic [5:0]        MU_BIAS     = 6'd33;
    localparam logic [CODE_W-1:0] ALAW_XOR    = 8'h55;

    typedef struct packed {
        opcode_t                     opcode;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [CODE_W-1:0]           code;
    } in_item_t;

endpackage

// File: hdl/g711_encoder.sv
// linear sample to companded byte, a-law or mu-law
module g711_encoder
    import g711_pkg::*;
(
    input  law_t                       law,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic [CODE_W-1:0]          code
);

    // highest set bit among bits 12..5, or 4 if none
    function automatic logic [3:0] lead_pos(input logic [MAG_W-1:0] m);
        logic [3:0] p;
        p = 4'd4;
        for (int i = 5; i < MAG_W; i++) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    logic [SAMPLE_W:0]   ext;
    logic [SAMPLE_W:0]   mag;
    logic [SAMPLE_W:0]   biased;
    logic [MAG_W-1:0]    sat;
    logic [3:0]          pos;
    logic [3:0]          shamt;
    logic [MAG_W-1:0]    shifted;
    logic [2:0]          seg;
    logic [CODE_W-1:0]   packed_code;

    always_comb begin
        ext = {sample[SAMPLE_W-1], sample};
        // 17 bits so that the magnitude of the most negative sample fits
        mag = sample[SAMPLE_W-1] ? (~ext + 17'd1) : ext;
        biased = (law == LAW_MULAW) ? (mag + {11'd0, MU_BIAS}) : mag;
        unique case (law)
            LAW_ALAW: begin
                sat = (biased > {4'd0, ALAW_LIMIT}) ? ALAW_LIMIT : biased[MAG_W-1:0];
            end
            LAW_MULAW: begin
                sat = (biased > {4'd0, MULAW_LIMIT}) ? MULAW_LIMIT : biased[MAG_W-1:0];
            end
            default: begin
                sat = '0;
            end
        endcase
        pos = lead_pos(sat);
        // a-law lowest segment takes bits 4..1
        shamt = (pos == 4'd4) ? 4'd1 : (pos - 4'd4);
        shifted = sat >> shamt;
        seg = (law == LAW_MULAW) ? 3'(pos - 4'd5) : 3'(pos - 4'd4);
        packed_code = {sample[SAMPLE_W-1], seg, shifted[3:0]};
        code = (law == LAW_MULAW) ? ~packed_code : (packed_code ^ ALAW_XOR);
    end

endmodule

// File: hdl/g711_decoder.sv
// companded byte to linear sample, a-law or mu-law
module g711_decoder
    import g711_pkg::*;
(
    input  law_t                    law,
    input  logic [CODE_W-1:0]       code,
    output logic signed [DEC_W-1:0] sample
);

    logic [CODE_W-1:0] x;
    logic [2:0]        seg;
    logic [MAG_W-1:0]  frame;
    logic [MAG_W-1:0]  mag;
    logic [DEC_W-1:0]  ext;

    always_comb begin
        x = (law == LAW_MULAW) ? ~code : (code ^ ALAW_XOR);
        seg = x[6:4];
        // leading one, mantissa and half-step bit, shifted into place
        frame = {7'd0, 1'b1, x[3:0], 1'b1};
        unique case (law)
            LAW_ALAW: begin
                if (seg == 3'd0) begin
                    mag = {8'd0, x[3:0], 1'b1};
                end else begin
                    mag = frame << (seg - 3'd1);
                end
            end
            LAW_MULAW: begin
                mag = (frame << seg) - {7'd0, MU_BIAS};
            end
            default: begin
                mag = '0;
            end
        endcase
        ext = {1'b0, mag};
        sample = x[7] ? $signed(~ext + 14'd1) : $signed(ext);
    end

endmodule

// File: hdl/g711_companding_codec_unit.sv
// g711 companding codec top level: input register, codec logic, result register
// the result register loads from the input register when it can take the item, so each
// result passes through both registers; throughput: one item per cycle unless the result
// side stalls; encode runs a priority encoder and a barrel shift, decode a shift and,
// for mu-law, a subtract, all between the input and result registers
// reset (aresetn low, synchronous) empties both stages and selects a-law
module g711_companding_codec_unit
    import g711_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic [CODE_W-1:0]          s_code_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [CODE_W-1:0]          m_code_out,
    output logic signed [DEC_W-1:0]    m_sample_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);

    law_t                    law_reg;
    logic                    in_valid_reg;
    in_item_t                in_item_reg;
    logic                    out_valid_reg;
    logic [CODE_W-1:0]       out_code_reg;
    logic signed [DEC_W-1:0] out_sample_reg;

    logic                    out_en;
    logic                    in_en;
    logic [CODE_W-1:0]       enc_code;
    logic signed [DEC_W-1:0] dec_sample;
    logic [CODE_W-1:0]       out_code_next;
    logic signed [DEC_W-1:0] out_sample_next;

    g711_encoder u_enc (
        .law    (law_reg),
        .sample (in_item_reg.sample),
        .code   (enc_code)
    );

    g711_decoder u_dec (
        .law    (law_reg),
        .code   (in_item_reg.code),
        .sample (dec_sample)
    );

    // input register moves on whenever it is empty or the result register can take it
    assign cfg_ready = 1'b1;
    assign out_en    = !out_valid_reg || m_ready;
    assign in_en     = !in_valid_reg || out_en;
    assign s_ready   = in_en;

    always_comb begin
        unique case (in_item_reg.opcode)
            OP_ENCODE: begin
                out_code_next   = enc_code;
                out_sample_next = '0;
            end
            OP_DECODE: begin
                out_code_next   = '0;
                out_sample_next = dec_sample;
            end
            default: begin
                out_code_next   = '0;
                out_sample_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            law_reg <= LAW_ALAW;
        end else if (cfg_valid && cfg_ready) begin
            law_reg <= law_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_valid) begin
            in_item_reg.opcode <= opcode_t'(s_opcode);
            in_item_reg.sample <= s_sample_in;
            in_item_reg.code   <= s_code_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && in_valid_reg) begin
            out_code_reg   <= out_code_next;
            out_sample_reg <= out_sample_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_code_out   = out_code_reg;
    assign m_sample_out = out_sample_reg;

endmodule

// File: hdl/g711_checker.sv
// port-level checks of the g711 companding codec, bound to the top level
`include "g711_companding_codec_unit_defines.svh"

module g711_checker
    import g711_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [CODE_W-1:0]          m_code_out,
    input logic signed [DEC_W-1:0]    m_sample_out
);

    // a stalled result keeps its item
    `G711_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_code_out) && $stable(m_sample_out), "stalled result changed")

    // reset empties the result register
    `G711_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // the unused result field is zero
    `G711_ASSERT(a_one_field, m_valid |-> (m_code_out == 8'd0) || (m_sample_out == 14'sd0), "both result fields nonzero")

    // decoded samples stay within the codec range
    `G711_ASSERT(a_range, m_valid |-> (m_sample_out <= 14'sd8031) && (m_sample_out >= -14'sd8031), "decoded sample out of range")

    // input only stalls behind a full, stalled result
    `G711_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready, "input stalled without output back-pressure")

endmodule

bind g711_companding_codec_unit g711_checker u_g711_checker (.*);

// File: bench/g711_codec_checker.sv
// result checker for the g711 companding codec: predicts each item and compares results
module g711_codec_checker
    import g711_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_opcode,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic [CODE_W-1:0]          s_code_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [CODE_W-1:0]          m_code_out,
    input  logic signed [DEC_W-1:0]    m_sample_out,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_data,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic signed [DEC_W-1:0]  sample;
    } codec_word_t;

    codec_word_t codec_words_q[$];
    law_t        cur_law;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        cur_law       = LAW_ALAW;
    end

    function automatic logic [CODE_W-1:0] alaw_compress(logic signed [SAMPLE_W-1:0] smp);
        int m;
        int pos;
        int mant;
        m = smp;
        if (m < 0) m = -m;
        if (m > int'(ALAW_LIMIT)) m = int'(ALAW_LIMIT);
        pos = 4;
        for (int p = 11; p >= 5; p--) begin
            if (pos == 4 && m[p]) pos = p;
        end
        // below segment 1 the mantissa is taken from bits 4..1
        mant = (pos == 4) ? ((m >> 1) & 15) : ((m >> (pos - 4)) & 15);
        return {smp[SAMPLE_W-1], 3'(pos - 4), 4'(mant)} ^ ALAW_XOR;
    endfunction

    function automatic logic [CODE_W-1:0] mulaw_compress(logic signed [SAMPLE_W-1:0] smp);
        int m;
        int pos;
        int mant;
        m = smp;
        if (m < 0) m = -m;
        m = m + int'(MU_BIAS);
        if (m > int'(MULAW_LIMIT)) m = int'(MULAW_LIMIT);
        pos = 5;
        for (int p = 12; p >= 6; p--) begin
            if (pos == 5 && m[p]) pos = p;
        end
        mant = (m >> (pos - 4)) & 15;
        return ~{smp[SAMPLE_W-1], 3'(pos - 5), 4'(mant)};
    endfunction

    function automatic logic signed [DEC_W-1:0] alaw_expand(logic [CODE_W-1:0] cd);
        logic [CODE_W-1:0] x;
        int mant;
        int pos;
        int mag;
        x    = cd ^ ALAW_XOR;
        mant = x[3:0];
        if (x[6:4] != 3'd0) begin
            pos = int'(x[6:4]) + 4;
            mag = (1 << pos) | (mant << (pos - 4)) | (1 << (pos - 5));
        end else begin
            mag = (mant << 1) | 1;
        end
        return DEC_W'(x[7] ? -mag : mag);
    endfunction

    function automatic logic signed [DEC_W-1:0] mulaw_expand(logic [CODE_W-1:0] cd);
        logic [CODE_W-1:0] x;
        int mant;
        int pos;
        int mag;
        x    = ~cd;
        mant = x[3:0];
        pos  = int'(x[6:4]) + 5;
        mag  = ((1 << pos) | (mant << (pos - 4)) | (1 << (pos - 5))) - int'(MU_BIAS);
        return DEC_W'(x[7] ? -mag : mag);
    endfunction

    function automatic codec_word_t codec_predict(law_t law, opcode_t op,
                                                  logic signed [SAMPLE_W-1:0] smp,
                                                  logic [CODE_W-1:0] cd);
        codec_word_t w;
        w = '0;
        if (op == OP_ENCODE) begin
            w.code = (law == LAW_MULAW) ? mulaw_compress(smp) : alaw_compress(smp);
        end else begin
            w.sample = (law == LAW_MULAW) ? mulaw_expand(cd) : alaw_expand(cd);
        end
        return w;
    endfunction

    always @(posedge aclk) begin : watch
        codec_word_t want;
        if (!aresetn) begin
            codec_words_q.delete();
            cur_law = LAW_ALAW;
        end else begin
            // results first: an item accepted at this edge cannot have its result yet
            if (m_valid && m_ready) begin
                if (codec_words_q.size() == 0) begin
                    $display("%0t: result code_out %02h sample_out %0d with no item pending",
                             $time, m_code_out, m_sample_out);
                    fail_count++;
                end else begin
                    want = codec_words_q.pop_front();
                    if (m_code_out !== want.code) begin
                        $display("%0t: code_out expected %02h actual %02h",
                                 $time, want.code, m_code_out);
                        fail_count++;
                    end
                    if (m_sample_out !== want.sample) begin
                        $display("%0t: sample_out expected %0d actual %0d",
                                 $time, want.sample, m_sample_out);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                codec_words_q.push_back(codec_predict(cur_law, opcode_t'(s_opcode),
                                                      s_sample_in, s_code_in));
            end
            if (cfg_valid && cfg_ready) cur_law = law_t'(cfg_data);
        end
        pending_count = codec_words_q.size();
    end

endmodule

// File: bench/tb_g711_companding_codec_unit.sv
// testbench top for the g711 companding codec: clock, reset, stimulus and verdict
module tb_g711_companding_codec_unit
    import g711_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_opcode = 1'b0;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic [CODE_W-1:0]          s_code_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [CODE_W-1:0]          m_code_out;
    logic signed [DEC_W-1:0]    m_sample_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_data = 1'b0;

    int fail_count;
    int pending_count;
    int tx_idle = 14;
    int rx_idle = 86;
    int rx_hold = 0;
    int cycle_cnt = 0;

    g711_companding_codec_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_sample_in  (s_sample_in),
        .s_code_in    (s_code_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_out   (m_code_out),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    g711_codec_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_sample_in   (s_sample_in),
        .s_code_in     (s_code_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_out    (m_code_out),
        .m_sample_out  (m_sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side: random back-pressure, or a counted hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input opcode_t op, input logic [SAMPLE_W-1:0] smp,
                             input logic [CODE_W-1:0] cd);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_sample_in <= smp;
        s_code_in   <= cd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering items and wait until every expected result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_law(input law_t law);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= law;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(3))
            0: begin
                v = SAMPLE_W'($urandom);
            end
            1: begin
                // small magnitudes, around the a-law bottom segment
                v = SAMPLE_W'(int'($urandom_range(128)) - 64);
            end
            2: begin
                v = SAMPLE_W'(int'($urandom_range(16400)) - 8200);
            end
            default: begin
                v = $urandom_range(1) ? 16'h7FFF - SAMPLE_W'($urandom_range(3))
                                      : 16'h8000 + SAMPLE_W'($urandom_range(3));
            end
        endcase
        return v;
    endfunction

    task automatic send_random(input int n);
        repeat (n) begin
            send_item($urandom_range(1) ? OP_DECODE : OP_ENCODE, pick_sample(),
                      CODE_W'($urandom_range(255)));
        end
    endtask

    task automatic run_corner_items();
        send_item(OP_ENCODE, 16'h0000, 8'hFF);
        send_item(OP_ENCODE, 16'hFFFF, 8'h00);
        send_item(OP_ENCODE, 16'h7FFF, 8'hA5);
        send_item(OP_ENCODE, 16'h8000, 8'h5A);
        send_item(OP_ENCODE, 16'd4095, 8'h00);
        send_item(OP_ENCODE, 16'd4096, 8'hFF);
        send_item(OP_ENCODE, 16'd8158, 8'h00);
        send_item(OP_ENCODE, 16'd8159, 8'h00);
        send_item(OP_ENCODE, 16'd31, 8'h00);
        send_item(OP_ENCODE, 16'hFFE0, 8'h00);
        send_item(OP_DECODE, 16'hFFFF, 8'h00);
        send_item(OP_DECODE, 16'h0000, 8'hFF);
        send_item(OP_DECODE, 16'h8000, 8'h55);
        send_item(OP_DECODE, 16'h7FFF, 8'hD5);
        send_item(OP_DECODE, 16'h1234, 8'h7F);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // a-law from reset, then mu-law
        run_corner_items();
        send_random(110);
        write_law(LAW_MULAW);
        run_corner_items();
        send_random(110);

        tx_idle = 86;
        rx_idle = 14;
        send_random(110);
        write_law(LAW_ALAW);
        send_random(110);

        tx_idle = 0;
        rx_idle = 0;
        send_random(90);
        // long hold-off on the result side while items keep coming
        rx_hold = 200;
        send_random(20);
        drain_results();
        write_law(LAW_MULAW);
        send_random(100);
        write_law(LAW_ALAW);
        send_random(50);

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
